// ===== design/dd_pkg.sv =====
// Shared types, constants and calendar helpers for the date difference block.
// Used by dd_lane, dd_merge and date_difference_days. No dependencies.
package dd_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned COUNT_W  = 22;
    localparam int unsigned DN_W     = 23;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned QUOT_W   = 8;
    localparam int unsigned MDAYS_W  = 9;
    localparam int unsigned MAXY_W   = 17;

    localparam int unsigned MAX_YEAR_DEF = 9999;
    localparam logic [COUNT_W-1:0] LIMIT_RESET = COUNT_W'(30);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};

    localparam int unsigned RECIP_100   = 5243;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam int unsigned RECIP_W     = 28;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_YEAR_ORDER  = 3'd1;
    localparam status_t ST_MONTH_ORDER = 3'd2;
    localparam status_t ST_DAY_ORDER   = 3'd3;
    localparam status_t ST_START_MONTH = 3'd4;
    localparam status_t ST_START_DAY   = 3'd5;
    localparam status_t ST_END_MONTH   = 3'd6;
    localparam status_t ST_END_DAY     = 3'd7;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [DN_W-1:0] day_num;
        logic            month_bad;
        logic            day_bad;
    } lane_res_t;

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y,
                                                      input logic [MAXY_W-1:0] max_y);
        logic [YEAR_W-1:0] r;
        r = y;
        if (MAXY_W'(y) > max_y)
        begin
            r = YEAR_W'(max_y);
        end
        return r;
    endfunction

    // exact for x below 25600
    function automatic logic [QUOT_W-1:0] div100(input logic [YEAR_W:0] x);
        logic [RECIP_W-1:0] p;
        p = RECIP_W'(x) * RECIP_W'(RECIP_100);
        return QUOT_W'(p >> RECIP_SHIFT);
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
            4'd2:    r = leap ? 5'd29 : 5'd28;
            default: r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic [MDAYS_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MDAYS_W-1:0] r;
        case (m)
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== design/dd_lane.sv =====
// One date lane: day number and month/day validity in three register stages.
// Depends on dd_pkg.
module dd_lane #(
    parameter int unsigned MAX_YEAR = dd_pkg::MAX_YEAR_DEF
) (
    input  logic                         clk,
    input  logic [dd_pkg::YEAR_W-1:0]    year,
    input  logic [dd_pkg::MONTH_W-1:0]   month,
    input  logic [dd_pkg::DAY_W-1:0]     day,
    output dd_pkg::lane_res_t            res
);

    logic [dd_pkg::YEAR_W-1:0]  yc;
    logic [dd_pkg::YEAR_W:0]    y_p99;
    logic [dd_pkg::YEAR_W:0]    y_p399;

    logic [dd_pkg::YEAR_W-1:0]  yc_a_reg;
    logic [dd_pkg::MONTH_W-1:0] m_a_reg;
    logic [dd_pkg::DAY_W-1:0]   d_a_reg;
    logic [dd_pkg::QUOT_W-1:0]  q0_a_reg;
    logic [dd_pkg::QUOT_W-1:0]  q1_a_reg;
    logic [dd_pkg::QUOT_W-1:0]  q4_a_reg;

    logic [dd_pkg::YEAR_W-1:0]  r100;
    logic                       leap;
    logic [dd_pkg::DAY_W-1:0]   dlen;
    logic [dd_pkg::YEAR_W:0]    y_p3;
    logic [dd_pkg::DN_W-1:0]    yterm_next;
    logic [dd_pkg::MDAYS_W-1:0] mdays_next;
    logic                       mbad_next;
    logic                       dbad_next;

    logic [dd_pkg::DN_W-1:0]    yterm_b_reg;
    logic [dd_pkg::QUOT_W-1:0]  sub_b_reg;
    logic [dd_pkg::MDAYS_W-1:0] mdays_b_reg;
    logic                       mbad_b_reg;
    logic                       dbad_b_reg;

    dd_pkg::lane_res_t          res_next;
    dd_pkg::lane_res_t          res_reg;

    assign yc     = dd_pkg::clamp_year(year, dd_pkg::MAXY_W'(MAX_YEAR));
    assign y_p99  = (dd_pkg::YEAR_W+1)'(yc) + 15'd99;
    assign y_p399 = ((dd_pkg::YEAR_W+1)'(yc) + 15'd399) >> 2;

    always_ff @(posedge clk)
    begin
        yc_a_reg <= yc;
        m_a_reg  <= month;
        d_a_reg  <= day;
        q0_a_reg <= dd_pkg::div100((dd_pkg::YEAR_W+1)'(yc));
        q1_a_reg <= dd_pkg::div100(y_p99);
        q4_a_reg <= dd_pkg::div100(y_p399);
    end

    always_comb
    begin
        r100       = yc_a_reg - dd_pkg::YEAR_W'(q0_a_reg * 7'd100);
        leap       = ((yc_a_reg[1:0] == 2'b00) && (r100 != '0))
                   || ((r100 == '0) && (q0_a_reg[1:0] == 2'b00));
        dlen       = dd_pkg::month_len(m_a_reg, leap);
        y_p3       = (dd_pkg::YEAR_W+1)'(yc_a_reg) + 15'd3;
        yterm_next = dd_pkg::DN_W'(yc_a_reg) * dd_pkg::DN_W'(365)
                   + dd_pkg::DN_W'(y_p3 >> 2);
        mdays_next = dd_pkg::month_start(m_a_reg)
                   + dd_pkg::MDAYS_W'(leap && (m_a_reg > dd_pkg::MONTH_FEB))
                   + dd_pkg::MDAYS_W'(d_a_reg);
        mbad_next  = (m_a_reg == '0) || (m_a_reg > dd_pkg::MONTH_DEC);
        dbad_next  = (d_a_reg == '0) || (d_a_reg > dlen);
    end

    always_ff @(posedge clk)
    begin
        yterm_b_reg <= yterm_next;
        sub_b_reg   <= q1_a_reg - q4_a_reg;
        mdays_b_reg <= mdays_next;
        mbad_b_reg  <= mbad_next;
        dbad_b_reg  <= dbad_next;
    end

    always_comb
    begin
        res_next.day_num   = yterm_b_reg - dd_pkg::DN_W'(sub_b_reg)
                           + dd_pkg::DN_W'(mdays_b_reg);
        res_next.month_bad = mbad_b_reg;
        res_next.day_bad   = dbad_b_reg;
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

// ===== design/dd_merge.sv =====
// Merge stage: combines both lanes and the order check into the result.
// Depends on dd_pkg.
module dd_merge (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  dd_pkg::status_t              order_status,
    input  dd_pkg::lane_res_t            start_res,
    input  dd_pkg::lane_res_t            end_res,
    input  logic [dd_pkg::COUNT_W-1:0]   limit,
    output logic                         out_valid,
    output dd_pkg::status_t              out_status,
    output logic [dd_pkg::COUNT_W-1:0]   out_count,
    output logic                         out_over
);

    dd_pkg::status_t              status_next;
    logic [dd_pkg::DN_W:0]        diff;
    logic [dd_pkg::COUNT_W-1:0]   count_next;
    logic                         over_next;

    logic                         valid_reg;
    dd_pkg::status_t              status_reg;
    logic [dd_pkg::COUNT_W-1:0]   count_reg;
    logic                         over_reg;

    always_comb
    begin
        if (order_status != dd_pkg::ST_OK)
            status_next = order_status;
        else if (start_res.month_bad)
            status_next = dd_pkg::ST_START_MONTH;
        else if (start_res.day_bad)
            status_next = dd_pkg::ST_START_DAY;
        else if (end_res.month_bad)
            status_next = dd_pkg::ST_END_MONTH;
        else if (end_res.day_bad)
            status_next = dd_pkg::ST_END_DAY;
        else
            status_next = dd_pkg::ST_OK;

        diff       = {1'b0, end_res.day_num} - {1'b0, start_res.day_num};
        count_next = '0;
        if (status_next == dd_pkg::ST_OK)
        begin
            if (diff > (dd_pkg::DN_W+1)'(dd_pkg::COUNT_MAX))
                count_next = dd_pkg::COUNT_MAX;
            else
                count_next = diff[dd_pkg::COUNT_W-1:0];
        end
        over_next = (status_next == dd_pkg::ST_OK) && (count_next >= limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        count_reg  <= count_next;
        over_reg   <= over_next;
    end

    assign out_valid  = valid_reg;
    assign out_status = status_reg;
    assign out_count  = count_reg;
    assign out_over   = over_reg;

endmodule

// ===== design/date_difference_days.sv =====
// Top level: two date lanes, the order check and the merge stage.
// Depends on dd_pkg, dd_lane and dd_merge.
//
//   channel   handshake              fields
//   request   start, busy            start_year/month/day, end_year/month/day
//   config    cfg_valid, cfg_ready   cfg_data (limit_days)
//   result    result_valid           status, day_count, over_limit
//
// One request per cycle; each result passes through three lane stages
// (reciprocal divides, year/month terms, final sum) and the merge register.
// busy stays low and cfg_ready stays high.
// Reset clears the pipeline valid bits and sets limit_days to 30.
// result_valid is a one-cycle strobe; the receiver cannot stall it.
module date_difference_days #(
    parameter int unsigned MAX_YEAR = dd_pkg::MAX_YEAR_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dd_pkg::YEAR_W-1:0]    start_year,
    input  logic [dd_pkg::MONTH_W-1:0]   start_month,
    input  logic [dd_pkg::DAY_W-1:0]     start_day,
    input  logic [dd_pkg::YEAR_W-1:0]    end_year,
    input  logic [dd_pkg::MONTH_W-1:0]   end_month,
    input  logic [dd_pkg::DAY_W-1:0]     end_day,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [dd_pkg::COUNT_W-1:0]   cfg_data,
    output logic                         result_valid,
    output logic [dd_pkg::STATUS_W-1:0]  status,
    output logic [dd_pkg::COUNT_W-1:0]   day_count,
    output logic                         over_limit
);

    logic                        accept;
    logic [dd_pkg::YEAR_W-1:0]   sy;
    logic [dd_pkg::YEAR_W-1:0]   ey;
    dd_pkg::status_t             order_next;

    logic                        v_a_reg;
    logic                        v_b_reg;
    logic                        v_c_reg;
    dd_pkg::status_t             ord_a_reg;
    dd_pkg::status_t             ord_b_reg;
    dd_pkg::status_t             ord_c_reg;
    logic [dd_pkg::COUNT_W-1:0]  limit_reg;

    dd_pkg::lane_res_t           start_res;
    dd_pkg::lane_res_t           end_res;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign sy = dd_pkg::clamp_year(start_year, dd_pkg::MAXY_W'(MAX_YEAR));
    assign ey = dd_pkg::clamp_year(end_year, dd_pkg::MAXY_W'(MAX_YEAR));

    always_comb
    begin
        if (sy > ey)
            order_next = dd_pkg::ST_YEAR_ORDER;
        else if ((sy == ey) && (start_month > end_month))
            order_next = dd_pkg::ST_MONTH_ORDER;
        else if ((sy == ey) && (start_month == end_month) && (start_day > end_day))
            order_next = dd_pkg::ST_DAY_ORDER;
        else
            order_next = dd_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg   <= 1'b0;
            v_b_reg   <= 1'b0;
            v_c_reg   <= 1'b0;
            limit_reg <= dd_pkg::LIMIT_RESET;
        end
        else
        begin
            v_a_reg <= accept;
            v_b_reg <= v_a_reg;
            v_c_reg <= v_b_reg;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ord_a_reg <= order_next;
        ord_b_reg <= ord_a_reg;
        ord_c_reg <= ord_b_reg;
    end

    dd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_start (
        .clk   (clk),
        .year  (start_year),
        .month (start_month),
        .day   (start_day),
        .res   (start_res)
    );

    dd_lane #(.MAX_YEAR(MAX_YEAR)) u_lane_end (
        .clk   (clk),
        .year  (end_year),
        .month (end_month),
        .day   (end_day),
        .res   (end_res)
    );

    dd_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (v_c_reg),
        .order_status (ord_c_reg),
        .start_res    (start_res),
        .end_res      (end_res),
        .limit        (limit_reg),
        .out_valid    (result_valid),
        .out_status   (status),
        .out_count    (day_count),
        .out_over     (over_limit)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 result_valid)
        else $error("request did not produce a result after four cycles");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != dd_pkg::ST_OK)) |-> ((day_count == '0) && !over_limit))
        else $error("error result carries a count or flag");

    a_over: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && over_limit) |-> (day_count >= limit_reg))
        else $error("over_limit set below the limit");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!v_c_reg) |=> !result_valid)
        else $error("result without a request in flight");

endmodule

// ===== bench/date_difference_days_tb.sv =====
// Self-checking bench for date_difference_days: directed and random date pairs,
// checked against a cycle-free day-count predictor kept in a scoreboard class.
// Depends on dd_pkg and the date_difference_days design files.
typedef struct packed {
    logic [dd_pkg::YEAR_W-1:0]  start_year;
    logic [dd_pkg::MONTH_W-1:0] start_month;
    logic [dd_pkg::DAY_W-1:0]   start_day;
    logic [dd_pkg::YEAR_W-1:0]  end_year;
    logic [dd_pkg::MONTH_W-1:0] end_month;
    logic [dd_pkg::DAY_W-1:0]   end_day;
} date_req_t;

typedef struct packed {
    dd_pkg::status_t            status;
    logic [dd_pkg::COUNT_W-1:0] count;
    logic                       over;
} day_span_t;

class day_span_board;
    day_span_t                  pending_spans[$];
    logic [dd_pkg::COUNT_W-1:0] limit_days;
    int unsigned                mismatches;

    function new();
        limit_days = dd_pkg::LIMIT_RESET;
        mismatches = 0;
    endfunction

    function logic [dd_pkg::YEAR_W-1:0] cap_year(logic [dd_pkg::YEAR_W-1:0] y);
        return (y > dd_pkg::MAX_YEAR_DEF) ? dd_pkg::YEAR_W'(dd_pkg::MAX_YEAR_DEF) : y;
    endfunction

    function bit leap_year(logic [dd_pkg::YEAR_W-1:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function logic [dd_pkg::DAY_W-1:0] month_days(logic [dd_pkg::YEAR_W-1:0] y,
                                                  logic [dd_pkg::MONTH_W-1:0] m);
        logic [dd_pkg::DAY_W-1:0] n;
        if (m == dd_pkg::MONTH_FEB)
            n = leap_year(y) ? 5'd29 : 5'd28;
        else if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11)
            n = 5'd30;
        else if (m >= 4'd1 && m <= dd_pkg::MONTH_DEC)
            n = 5'd31;
        else
            n = 5'd0;
        return n;
    endfunction

    function logic [23:0] day_index(logic [dd_pkg::YEAR_W-1:0] y,
                                    logic [dd_pkg::MONTH_W-1:0] m,
                                    logic [dd_pkg::DAY_W-1:0] d);
        logic [23:0] n;
        logic [23:0] yy;
        int          i;
        yy = 24'(y);
        n = yy * 24'd365 + (yy + 24'd3) / 24'd4 - (yy + 24'd99) / 24'd100
            + (yy + 24'd399) / 24'd400;
        for (i = 1; i < int'(m); i++)
            n = n + 24'(month_days(y, dd_pkg::MONTH_W'(i)));
        return n + 24'(d);
    endfunction

    function day_span_t predict(date_req_t r);
        day_span_t                 s;
        logic [dd_pkg::YEAR_W-1:0] sy;
        logic [dd_pkg::YEAR_W-1:0] ey;
        logic [23:0]               span;
        sy = cap_year(r.start_year);
        ey = cap_year(r.end_year);
        s.status = dd_pkg::ST_OK;
        s.count = '0;
        s.over = 1'b0;
        if (sy > ey)
            s.status = dd_pkg::ST_YEAR_ORDER;
        else if (sy == ey && r.start_month > r.end_month)
            s.status = dd_pkg::ST_MONTH_ORDER;
        else if (sy == ey && r.start_month == r.end_month && r.start_day > r.end_day)
            s.status = dd_pkg::ST_DAY_ORDER;
        else if (r.start_month < 4'd1 || r.start_month > dd_pkg::MONTH_DEC)
            s.status = dd_pkg::ST_START_MONTH;
        else if (r.start_day < 5'd1 || r.start_day > month_days(sy, r.start_month))
            s.status = dd_pkg::ST_START_DAY;
        else if (r.end_month < 4'd1 || r.end_month > dd_pkg::MONTH_DEC)
            s.status = dd_pkg::ST_END_MONTH;
        else if (r.end_day < 5'd1 || r.end_day > month_days(ey, r.end_month))
            s.status = dd_pkg::ST_END_DAY;
        if (s.status == dd_pkg::ST_OK)
        begin
            span = day_index(ey, r.end_month, r.end_day)
                   - day_index(sy, r.start_month, r.start_day);
            s.count = (span > 24'(dd_pkg::COUNT_MAX)) ? dd_pkg::COUNT_MAX
                                                       : span[dd_pkg::COUNT_W-1:0];
            s.over = (s.count >= limit_days);
        end
        return s;
    endfunction

    function void note_request(date_req_t r);
        pending_spans.push_back(predict(r));
    endfunction

    task report_mismatch(string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task check_result(dd_pkg::status_t st, logic [dd_pkg::COUNT_W-1:0] cnt, logic ov);
        day_span_t want;
        if (pending_spans.size() == 0)
        begin
            report_mismatch($sformatf("result status %0d count %0d with no request waiting",
                                      st, cnt));
        end
        else
        begin
            want = pending_spans.pop_front();
            if (st !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", st, want.status));
            if (cnt !== want.count)
                report_mismatch($sformatf("day_count %0d, want %0d", cnt, want.count));
            if (ov !== want.over)
                report_mismatch($sformatf("over_limit %0b, want %0b", ov, want.over));
        end
    endtask

    function int unsigned outstanding();
        return pending_spans.size();
    endfunction
endclass

module date_difference_days_tb;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic [dd_pkg::YEAR_W-1:0]   start_year = '0;
    logic [dd_pkg::MONTH_W-1:0]  start_month = '0;
    logic [dd_pkg::DAY_W-1:0]    start_day = '0;
    logic [dd_pkg::YEAR_W-1:0]   end_year = '0;
    logic [dd_pkg::MONTH_W-1:0]  end_month = '0;
    logic [dd_pkg::DAY_W-1:0]    end_day = '0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [dd_pkg::COUNT_W-1:0]  cfg_data = '0;
    logic                        result_valid;
    logic [dd_pkg::STATUS_W-1:0] status;
    logic [dd_pkg::COUNT_W-1:0]  day_count;
    logic                        over_limit;

    day_span_board               book = new();
    int unsigned                 cycles = 0;
    int unsigned                 burst_left = 0;
    bit                          burst_fast = 1'b0;

    date_difference_days #(
        .MAX_YEAR(dd_pkg::MAX_YEAR_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .start_year(start_year),
        .start_month(start_month),
        .start_day(start_day),
        .end_year(end_year),
        .end_month(end_month),
        .end_day(end_day),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .result_valid(result_valid),
        .status(status),
        .day_count(day_count),
        .over_limit(over_limit)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1)
            book.check_result(status, day_count, over_limit);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic date_req_t make_req(int unsigned sy, int unsigned sm, int unsigned sd,
                                           int unsigned ey, int unsigned em, int unsigned ed);
        date_req_t r;
        r.start_year = dd_pkg::YEAR_W'(sy);
        r.start_month = dd_pkg::MONTH_W'(sm);
        r.start_day = dd_pkg::DAY_W'(sd);
        r.end_year = dd_pkg::YEAR_W'(ey);
        r.end_month = dd_pkg::MONTH_W'(em);
        r.end_day = dd_pkg::DAY_W'(ed);
        return r;
    endfunction

    function automatic int unsigned next_gap();
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(5, 30);
            burst_fast = ($urandom_range(0, 2) == 0);
        end
        burst_left--;
        return burst_fast ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic logic [dd_pkg::YEAR_W-1:0] pick_year();
        logic [dd_pkg::YEAR_W-1:0] y;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 7))
                    0: y = 14'd0;
                    1: y = 14'd4;
                    2: y = 14'd100;
                    3: y = 14'd400;
                    4: y = 14'd1900;
                    5: y = 14'd2000;
                    6: y = 14'd2100;
                    default: y = 14'd9999;
                endcase
            end
            1: y = dd_pkg::YEAR_W'($urandom_range(10000, 16383));
            default: y = dd_pkg::YEAR_W'($urandom_range(0, 9999));
        endcase
        return y;
    endfunction

    function automatic logic [dd_pkg::MONTH_W-1:0] bad_month();
        return ($urandom_range(0, 1) == 0) ? 4'd0
                                           : dd_pkg::MONTH_W'($urandom_range(13, 15));
    endfunction

    function automatic logic [dd_pkg::DAY_W-1:0] bad_day(logic [dd_pkg::DAY_W-1:0] len);
        logic [dd_pkg::DAY_W-1:0] d;
        if (len == 5'd31 || $urandom_range(0, 1) == 0)
            d = 5'd0;
        else
            d = dd_pkg::DAY_W'($urandom_range(int'(len) + 1, 31));
        return d;
    endfunction

    function automatic date_req_t random_request();
        date_req_t   r;
        date_req_t   swapped;
        int unsigned kind;
        int unsigned mode;
        kind = $urandom_range(0, 99);
        if (kind < 15)
        begin
            r.start_year = dd_pkg::YEAR_W'($urandom);
            r.start_month = dd_pkg::MONTH_W'($urandom);
            r.start_day = dd_pkg::DAY_W'($urandom);
            r.end_year = dd_pkg::YEAR_W'($urandom);
            r.end_month = dd_pkg::MONTH_W'($urandom);
            r.end_day = dd_pkg::DAY_W'($urandom);
        end
        else
        begin
            mode = $urandom_range(0, 2);
            r.start_year = pick_year();
            r.start_month = dd_pkg::MONTH_W'($urandom_range(1, 12));
            r.start_day = dd_pkg::DAY_W'($urandom_range(1, book.month_days(
                book.cap_year(r.start_year), r.start_month)));
            if (mode == 0)
                r.end_year = r.start_year;
            else if (mode == 1)
                r.end_year = (r.start_year > 14'd16380) ? r.start_year
                             : r.start_year + dd_pkg::YEAR_W'($urandom_range(0, 3));
            else
                r.end_year = pick_year();
            if (mode == 0 && $urandom_range(0, 1) == 1)
                r.end_month = r.start_month;
            else
                r.end_month = dd_pkg::MONTH_W'($urandom_range(1, 12));
            r.end_day = dd_pkg::DAY_W'($urandom_range(1, book.month_days(
                book.cap_year(r.end_year), r.end_month)));
            if ({book.cap_year(r.start_year), r.start_month, r.start_day}
                > {book.cap_year(r.end_year), r.end_month, r.end_day})
            begin
                swapped = r;
                r.start_year = swapped.end_year;
                r.start_month = swapped.end_month;
                r.start_day = swapped.end_day;
                r.end_year = swapped.start_year;
                r.end_month = swapped.start_month;
                r.end_day = swapped.start_day;
            end
            if (kind < 30)
            begin
                case ($urandom_range(0, 4))
                    0: r.start_month = bad_month();
                    1: r.start_day = bad_day(book.month_days(book.cap_year(r.start_year),
                                                             r.start_month));
                    2: r.end_month = bad_month();
                    3: r.end_day = bad_day(book.month_days(book.cap_year(r.end_year),
                                                           r.end_month));
                    default:
                    begin
                        swapped = r;
                        r.start_year = swapped.end_year;
                        r.start_month = swapped.end_month;
                        r.start_day = swapped.end_day;
                        r.end_year = swapped.start_year;
                        r.end_month = swapped.start_month;
                        r.end_day = swapped.start_day;
                    end
                endcase
            end
        end
        return r;
    endfunction

    task idle_for(int unsigned n);
        if (n > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            start_year <= dd_pkg::YEAR_W'($urandom);
            start_month <= dd_pkg::MONTH_W'($urandom);
            start_day <= dd_pkg::DAY_W'($urandom);
            end_year <= dd_pkg::YEAR_W'($urandom);
            end_month <= dd_pkg::MONTH_W'($urandom);
            end_day <= dd_pkg::DAY_W'($urandom);
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task send_request(date_req_t r);
        idle_for(next_gap());
        @(negedge clk);
        start <= 1'b1;
        start_year <= r.start_year;
        start_month <= r.start_month;
        start_day <= r.start_day;
        end_year <= r.end_year;
        end_month <= r.end_month;
        end_day <= r.end_day;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        book.note_request(r);
    endtask

    task drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (book.outstanding() != 0)
            @(posedge clk);
    endtask

    task set_limit(logic [dd_pkg::COUNT_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        book.limit_days = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    logic [dd_pkg::COUNT_W-1:0] limit_plan [6];
    logic [dd_pkg::COUNT_W-1:0] max_span;
    day_span_t                  max_pred;
    int                         p;
    int                         k;

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // limit at its reset value of 30
        send_request(make_req(2024, 1, 1, 2024, 1, 1));
        send_request(make_req(2024, 1, 1, 2024, 1, 30));
        send_request(make_req(2024, 1, 1, 2024, 1, 31));
        send_request(make_req(2024, 1, 1, 2024, 2, 1));
        send_request(make_req(2000, 2, 29, 2000, 3, 1));
        send_request(make_req(1900, 2, 29, 1901, 1, 1));
        send_request(make_req(2100, 1, 1, 2100, 2, 29));
        send_request(make_req(0, 2, 29, 0, 3, 1));
        send_request(make_req(2001, 1, 1, 2000, 1, 1));
        send_request(make_req(2000, 5, 1, 2000, 4, 1));
        send_request(make_req(2000, 5, 10, 2000, 5, 9));
        send_request(make_req(2000, 15, 1, 2000, 14, 1));
        send_request(make_req(2000, 2, 31, 2000, 2, 30));
        send_request(make_req(2000, 0, 1, 2001, 1, 1));
        send_request(make_req(2000, 13, 1, 2001, 1, 1));
        send_request(make_req(2000, 1, 0, 2001, 1, 1));
        send_request(make_req(2000, 4, 31, 2001, 1, 1));
        send_request(make_req(2000, 1, 1, 2001, 0, 5));
        send_request(make_req(2000, 1, 1, 2001, 15, 5));
        send_request(make_req(2000, 1, 1, 2001, 3, 0));
        send_request(make_req(2000, 1, 1, 2001, 9, 31));
        send_request(make_req(16383, 12, 31, 9999, 12, 31));
        send_request(make_req(10000, 1, 1, 9999, 12, 31));
        send_request(make_req(0, 1, 1, 16383, 12, 31));
        send_request(make_req(16383, 15, 31, 16383, 15, 31));
        send_request(make_req(0, 0, 0, 0, 0, 0));

        max_pred = book.predict(make_req(0, 1, 1, 9999, 12, 31));
        max_span = max_pred.count;
        limit_plan[0] = '0;
        limit_plan[1] = {dd_pkg::COUNT_W{1'b1}};
        limit_plan[2] = max_span;
        limit_plan[3] = max_span + 1'b1;
        limit_plan[4] = dd_pkg::COUNT_W'(365);
        limit_plan[5] = dd_pkg::COUNT_W'($urandom_range(0, 3652500));

        for (p = 0; p < 6; p++)
        begin
            set_limit(limit_plan[p]);
            send_request(make_req(0, 1, 1, 9999, 12, 31));
            for (k = 0; k < 74; k++)
            begin
                if (k == 37 || $urandom_range(0, 49) == 0)
                    drain_results();
                send_request(random_request());
            end
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (book.mismatches == 0 && book.outstanding() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/dd_pkg.sv
design/dd_lane.sv
design/dd_merge.sv
design/date_difference_days.sv
bench/date_difference_days_tb.sv
